// ----- src/i2p_pkg.sv -----
// Package: operator codes, sequencer states, stack control word and symbol tables.
`timescale 1ns / 1ps

package i2p_pkg;

    // operator codes as held on the stack; CLOSE and OPERAND are never stored
    localparam logic [2:0] CODE_ADD     = 3'd0;
    localparam logic [2:0] CODE_SUB     = 3'd1;
    localparam logic [2:0] CODE_MUL     = 3'd2;
    localparam logic [2:0] CODE_DIV     = 3'd3;
    localparam logic [2:0] CODE_POW     = 3'd4;
    localparam logic [2:0] CODE_OPEN    = 3'd5;
    localparam logic [2:0] CODE_CLOSE   = 3'd6;
    localparam logic [2:0] CODE_OPERAND = 3'd7;

    localparam logic [7:0] CHAR_ADD   = 8'h2B;
    localparam logic [7:0] CHAR_SUB   = 8'h2D;
    localparam logic [7:0] CHAR_MUL   = 8'h2A;
    localparam logic [7:0] CHAR_DIV   = 8'h2F;
    localparam logic [7:0] CHAR_POW   = 8'h5E;
    localparam logic [7:0] CHAR_OPEN  = 8'h28;
    localparam logic [7:0] CHAR_CLOSE = 8'h29;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_OPER,
        ST_CLOSE,
        ST_FLUSH,
        ST_DONE
    } state_t;

    // one stack operation per cycle: push, pop or neither
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [2:0] code;
    } stack_ctrl_t;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] code;
        case (c)
            CHAR_ADD:   code = CODE_ADD;
            CHAR_SUB:   code = CODE_SUB;
            CHAR_MUL:   code = CODE_MUL;
            CHAR_DIV:   code = CODE_DIV;
            CHAR_POW:   code = CODE_POW;
            CHAR_OPEN:  code = CODE_OPEN;
            CHAR_CLOSE: code = CODE_CLOSE;
            default:    code = CODE_OPERAND;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] sym_of(input logic [2:0] code);
        logic [7:0] c;
        case (code)
            CODE_ADD: c = CHAR_ADD;
            CODE_SUB: c = CHAR_SUB;
            CODE_MUL: c = CHAR_MUL;
            CODE_DIV: c = CHAR_DIV;
            CODE_POW: c = CHAR_POW;
            default:  c = CHAR_OPEN;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] rank_of(input logic [2:0] code);
        logic [1:0] r;
        case (code)
            CODE_ADD, CODE_SUB: r = 2'd0;
            CODE_MUL, CODE_DIV: r = 2'd1;
            CODE_POW:           r = 2'd2;
            default:            r = 2'd3;
        endcase
        return r;
    endfunction

endpackage

// ----- src/infix_to_postfix_converter.sv -----
// Infix to postfix converter: one character per word in, postfix characters out.
// An accepted operand goes into a one-deep hold register and moves to the output register
// when the next result is made or the word ends; an operator or ')' pops the single-ported
// stack one entry at a time, and a last word also flushes the stack entry by entry.
// A stalled output holds the sequencer; input is accepted only when it is idle.
// Reset (aresetn low, synchronous) empties the stack and clears the overflow flag.
`timescale 1ns / 1ps

module infix_to_postfix_converter #(
    parameter int STACK_DEPTH = 32
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_in
    input  logic       s_tlast,   // expr_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] char_out
    output logic       m_tlast,   // run_last
    output logic [1:0] m_tuser    // [0] expr_done, [1] overflow
);
    import i2p_pkg::*;

    state_t      state_reg, state_next;
    logic [2:0]  code_reg, code_next;
    logic        last_reg, last_next;
    logic        pend_valid_reg, pend_valid_next;
    logic [7:0]  pend_char_reg, pend_char_next;
    logic        flag_reg, flag_next;
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_char_reg, m_char_next;
    logic        m_last_reg, m_last_next;
    logic        m_done_reg, m_done_next;
    logic        m_ovf_reg, m_ovf_next;

    stack_ctrl_t stk_ctrl;
    logic [2:0]  top_code;
    logic        stk_empty;
    logic        stk_full;

    logic        out_free;
    logic        can_emit;
    logic        emit;
    logic [7:0]  emit_char;
    logic        pop_op;

    i2p_op_stack #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (stk_ctrl),
        .top_code (top_code),
        .empty    (stk_empty),
        .full     (stk_full)
    );

    assign out_free = !m_valid_reg || m_tready;
    // a new result moves the held one out first, so the output must have room
    assign can_emit = !pend_valid_reg || out_free;
    // pop rule for an incoming operator
    assign pop_op = !stk_empty && (top_code != CODE_OPEN) &&
                    ((rank_of(top_code) > rank_of(code_reg)) ||
                     ((rank_of(top_code) == rank_of(code_reg)) &&
                      (code_reg != CODE_POW) && (code_reg != CODE_OPEN)));

    // sequencer: next state, stack control, result hand-off
    always_comb begin
        state_next      = state_reg;
        code_next       = code_reg;
        last_next       = last_reg;
        pend_valid_next = pend_valid_reg;
        pend_char_next  = pend_char_reg;
        flag_next       = flag_reg;
        m_valid_next    = m_valid_reg && !m_tready;
        m_char_next     = m_char_reg;
        m_last_next     = m_last_reg;
        m_done_next     = m_done_reg;
        m_ovf_next      = m_ovf_reg;
        stk_ctrl.push   = 1'b0;
        stk_ctrl.pop    = 1'b0;
        stk_ctrl.code   = code_reg;
        emit            = 1'b0;
        emit_char       = sym_of(top_code);
        s_tready        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    code_next = classify(s_tdata);
                    last_next = s_tlast;
                    if (classify(s_tdata) == CODE_OPERAND) begin
                        emit       = 1'b1;
                        emit_char  = s_tdata;
                        state_next = s_tlast ? ST_FLUSH : ST_DONE;
                    end else if (classify(s_tdata) == CODE_CLOSE) begin
                        state_next = ST_CLOSE;
                    end else begin
                        state_next = ST_OPER;
                    end
                end
            end
            ST_OPER: begin
                if (pop_op) begin
                    if (can_emit) begin
                        emit         = 1'b1;
                        stk_ctrl.pop = 1'b1;
                    end
                end else begin
                    stk_ctrl.push = 1'b1;
                    if (stk_full) begin
                        flag_next = 1'b1;
                    end
                    state_next = last_reg ? ST_FLUSH : ST_DONE;
                end
            end
            ST_CLOSE: begin
                if (stk_empty) begin
                    state_next = last_reg ? ST_FLUSH : ST_DONE;
                end else if (top_code == CODE_OPEN) begin
                    stk_ctrl.pop = 1'b1;
                    state_next   = last_reg ? ST_FLUSH : ST_DONE;
                end else if (can_emit) begin
                    emit         = 1'b1;
                    stk_ctrl.pop = 1'b1;
                end
            end
            ST_FLUSH: begin
                if (stk_empty) begin
                    state_next = ST_DONE;
                end else if (top_code == CODE_OPEN) begin
                    stk_ctrl.pop = 1'b1;
                end else if (can_emit) begin
                    emit         = 1'b1;
                    stk_ctrl.pop = 1'b1;
                end
            end
            ST_DONE: begin
                // the held result is the final one of this word
                if (!pend_valid_reg) begin
                    if (last_reg) begin
                        flag_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    m_valid_next    = 1'b1;
                    m_char_next     = pend_char_reg;
                    m_last_next     = 1'b1;
                    m_done_next     = last_reg;
                    m_ovf_next      = flag_reg;
                    pend_valid_next = 1'b0;
                    if (last_reg) begin
                        flag_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // one-deep hold so the last result of a word can be marked
        if (emit) begin
            if (pend_valid_reg) begin
                m_valid_next = 1'b1;
                m_char_next  = pend_char_reg;
                m_last_next  = 1'b0;
                m_done_next  = 1'b0;
                m_ovf_next   = flag_reg;
            end
            pend_valid_next = 1'b1;
            pend_char_next  = emit_char;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            flag_reg       <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            flag_reg       <= flag_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        code_reg      <= code_next;
        last_reg      <= last_next;
        pend_char_reg <= pend_char_next;
        m_char_reg    <= m_char_next;
        m_last_reg    <= m_last_next;
        m_done_reg    <= m_done_next;
        m_ovf_reg     <= m_ovf_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_char_reg;
    assign m_tlast  = m_last_reg;
    assign m_tuser  = {m_ovf_reg, m_done_reg};

endmodule

// ----- src/i2p_op_stack.sv -----
// Operator stack: RAM with fill count and a registered top-of-stack read.
`timescale 1ns / 1ps

module i2p_op_stack #(
    parameter int STACK_DEPTH = 32
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  i2p_pkg::stack_ctrl_t ctrl,
    output logic [2:0]          top_code,
    output logic                empty,
    output logic                full
);
    import i2p_pkg::*;

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int AW    = $clog2(STACK_DEPTH);

    logic [2:0]       mem [STACK_DEPTH];
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic [CNT_W-1:0] rd_cnt;
    logic [AW-1:0]    rd_addr;
    logic [AW-1:0]    wr_addr;
    logic             wr_en;
    logic [2:0]       top_reg;

    // fill count
    always_comb begin
        count_next = count_reg;
        if (wr_en) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctrl.pop && !empty) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(STACK_DEPTH));
    assign wr_en   = ctrl.push && !full;
    assign wr_addr = count_reg[AW-1:0];
    // read the entry that will be on top after this cycle
    assign rd_cnt  = count_next - CNT_W'(1);
    assign rd_addr = rd_cnt[AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    // memory write and registered top read, with bypass of a fresh push
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= ctrl.code;
        end
        if (wr_en && (wr_addr == rd_addr)) begin
            top_reg <= ctrl.code;
        end else begin
            top_reg <= mem[rd_addr];
        end
    end

    assign top_code = top_reg;

endmodule
